// File: rtl/deque_with_search_macros.svh
// assertion helpers for the rtl file deque_with_search.sv
`ifndef DEQUE_WITH_SEARCH_MACROS_SVH
`define DEQUE_WITH_SEARCH_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define DWS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define DWS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/dws_pkg.sv
package dws_pkg;

    // ring geometry
    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // field widths
    localparam int FUNC_W = 3;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;
    localparam int POS_W  = 5;

    // operation codes
    localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_SEARCH     = 3'd4;
    localparam logic [FUNC_W-1:0] FN_DUMP       = 3'd5;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic signed [DATA_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] element;
        logic                     last;
    } res_t;

    // ring index of base + off, both below DEPTH
    function automatic logic [IDX_W-1:0] ring_slot(
        input logic [IDX_W-1:0] base,
        input logic [IDX_W-1:0] off
    );
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (IDX_W + 1)'(DEPTH))
        begin
            sum = sum - (IDX_W + 1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

// File: rtl/dws_ram.sv
module dws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/deque_with_search.sv
// bounded double-ended queue of signed 32-bit values held in a ring of
// dws_pkg::DEPTH entries (one ram with a registered read port), tracked by a
// front index and an occupancy count. each command transfer carries an
// operation (push front, push back, pop front, pop back, search, dump) and a
// value. push and pop give one result transfer. search walks the held
// entries from the front through the single read port and one equality
// comparator, and reports the first 1-based match position or not-found.
// dump gives one result transfer per held element, front to back, with last
// set on the final one. a full push reports overflow, an empty pop, search or
// dump reports underflow; operation codes 6 and 7 are dropped without a
// result. one command is in flight at a time. search and dump walk the held
// entries through the ram read port one entry per cycle; a search walk keeps
// reading under res_stall and waits only on its result, while res_stall
// holds a dump walk in place without losing the current entry. the result
// sits in an output register, so a new command is taken as soon as the last
// result of the previous one has been loaded there.
`include "deque_with_search_macros.svh"

module deque_with_search (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  dws_pkg::cmd_t cmd,
    output logic          res_valid,
    input  logic          res_stall,
    output dws_pkg::res_t res
);

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_WALK = 2'd2;

    // control state
    logic [1:0]                  state_reg,     state_next;
    logic [dws_pkg::IDX_W-1:0]   front_reg,     front_next;
    logic [dws_pkg::CNT_W-1:0]   count_reg,     count_next;
    logic [dws_pkg::IDX_W-1:0]   walk_reg,      walk_next;
    logic                        res_valid_reg, res_valid_next;

    // latched command and result payload
    logic [dws_pkg::FUNC_W-1:0]  func_reg;
    logic [dws_pkg::DATA_W-1:0]  key_reg;
    dws_pkg::res_t               res_reg,       res_next;

    // ring ram port
    logic                        ram_we;
    logic [dws_pkg::IDX_W-1:0]   ram_waddr;
    logic                        ram_re;
    logic [dws_pkg::IDX_W-1:0]   ram_raddr;
    logic [dws_pkg::DATA_W-1:0]  ram_rdata;

    logic                        cmd_xfer;
    logic                        res_load;
    logic                        out_free;
    logic                        is_full;
    logic                        is_empty;
    logic [dws_pkg::IDX_W-1:0]   front_dec;
    logic [dws_pkg::CNT_W-1:0]   walk_plus;
    logic                        last_entry;
    logic [31:0]                 pos_wide;
    logic                        key_match;

    function automatic dws_pkg::res_t make_res(
        input logic [dws_pkg::STAT_W-1:0] status,
        input logic [dws_pkg::POS_W-1:0]  position,
        input logic [dws_pkg::DATA_W-1:0] element,
        input logic                       last
    );
        dws_pkg::res_t r;
        r.status   = status;
        r.position = position;
        r.element  = element;
        r.last     = last;
        return r;
    endfunction

    dws_ram #(
        .WIDTH (dws_pkg::DATA_W),
        .DEPTH (dws_pkg::DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (key_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // handshakes: only idle takes a command, output register frees on transfer
    assign cmd_stall = (state_reg != S_IDLE);
    assign cmd_xfer  = cmd_valid && !cmd_stall;
    assign out_free  = !res_valid_reg || !res_stall;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign is_full   = (count_reg == dws_pkg::CNT_W'(dws_pkg::DEPTH));
    assign is_empty  = (count_reg == '0);
    assign front_dec = (front_reg == '0) ? dws_pkg::IDX_W'(dws_pkg::DEPTH - 1)
                                         : front_reg - dws_pkg::IDX_W'(1);

    // walk bookkeeping: 1-based position of the entry now on the read port
    assign walk_plus  = dws_pkg::CNT_W'(walk_reg) + dws_pkg::CNT_W'(1);
    assign last_entry = (walk_plus == count_reg);
    assign pos_wide   = 32'(walk_plus);

    // the shared comparator
    assign key_match  = (ram_rdata == key_reg);

    always_comb
    begin
        state_next = state_reg;
        front_next = front_reg;
        count_next = count_reg;
        walk_next  = walk_reg;
        ram_we     = 1'b0;
        ram_waddr  = front_reg;
        ram_re     = 1'b0;
        ram_raddr  = dws_pkg::ring_slot(front_reg, walk_reg + dws_pkg::IDX_W'(1));
        res_load   = 1'b0;
        res_next   = res_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_xfer)
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                case (func_reg)
                    dws_pkg::FN_PUSH_FRONT, dws_pkg::FN_PUSH_BACK:
                    begin
                        if (out_free)
                        begin
                            res_load   = 1'b1;
                            state_next = S_IDLE;
                            if (is_full)
                            begin
                                res_next = make_res(dws_pkg::ST_FULL, '0, '0, 1'b1);
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + dws_pkg::CNT_W'(1);
                                res_next   = make_res(dws_pkg::ST_OK, '0, '0, 1'b1);
                                if (func_reg == dws_pkg::FN_PUSH_FRONT)
                                begin
                                    ram_waddr  = front_dec;
                                    front_next = front_dec;
                                end
                                else
                                begin
                                    ram_waddr = dws_pkg::ring_slot(front_reg,
                                        count_reg[dws_pkg::IDX_W-1:0]);
                                end
                            end
                        end
                    end

                    dws_pkg::FN_POP_FRONT, dws_pkg::FN_POP_BACK:
                    begin
                        if (out_free)
                        begin
                            res_load   = 1'b1;
                            state_next = S_IDLE;
                            if (is_empty)
                            begin
                                res_next = make_res(dws_pkg::ST_EMPTY, '0, '0, 1'b1);
                            end
                            else
                            begin
                                count_next = count_reg - dws_pkg::CNT_W'(1);
                                res_next   = make_res(dws_pkg::ST_OK, '0, '0, 1'b1);
                                if (func_reg == dws_pkg::FN_POP_FRONT)
                                begin
                                    front_next = dws_pkg::ring_slot(front_reg,
                                        dws_pkg::IDX_W'(1));
                                end
                            end
                        end
                    end

                    dws_pkg::FN_SEARCH, dws_pkg::FN_DUMP:
                    begin
                        if (is_empty)
                        begin
                            if (out_free)
                            begin
                                res_load   = 1'b1;
                                state_next = S_IDLE;
                                res_next   = make_res(dws_pkg::ST_EMPTY, '0, '0, 1'b1);
                            end
                        end
                        else
                        begin
                            // fetch the front entry, data shows up in the walk state
                            ram_re     = 1'b1;
                            ram_raddr  = front_reg;
                            walk_next  = '0;
                            state_next = S_WALK;
                        end
                    end

                    default:
                    begin
                        // undefined operation, dropped silently
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_WALK:
            begin
                if (func_reg == dws_pkg::FN_SEARCH)
                begin
                    if (key_match || last_entry)
                    begin
                        if (out_free)
                        begin
                            res_load   = 1'b1;
                            state_next = S_IDLE;
                            if (key_match)
                            begin
                                res_next = make_res(dws_pkg::ST_OK,
                                    pos_wide[dws_pkg::POS_W-1:0], '0, 1'b1);
                            end
                            else
                            begin
                                res_next = make_res(dws_pkg::ST_NOTFOUND, '0, '0, 1'b1);
                            end
                        end
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        walk_next = walk_reg + dws_pkg::IDX_W'(1);
                    end
                end
                else
                begin
                    // dump: one entry per result transfer, read port held on stall
                    if (out_free)
                    begin
                        res_load = 1'b1;
                        res_next = make_res(dws_pkg::ST_OK, '0, ram_rdata, last_entry);
                        if (last_entry)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            ram_re    = 1'b1;
                            walk_next = walk_reg + dws_pkg::IDX_W'(1);
                        end
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_stall)
        begin
            res_valid_next = res_valid_reg;
        end
        else
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            walk_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            walk_reg      <= walk_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_xfer)
        begin
            func_reg <= cmd.func;
            key_reg  <= cmd.value;
        end
        if (res_load)
        begin
            res_reg <= res_next;
        end
    end

    // occupancy never goes past the ring size
    `DWS_ASSERT_IMPL(a_count_range, 1'b1, count_reg <= dws_pkg::CNT_W'(dws_pkg::DEPTH), "occupancy above depth")

    // a held result is never overwritten
    `DWS_ASSERT_IMPL(a_no_overwrite, res_valid_reg && res_stall, !res_load, "result register overwritten while stalled")

    // the walk stays inside the occupied span
    `DWS_ASSERT_IMPL(a_walk_span, state_reg == S_WALK, dws_pkg::CNT_W'(walk_reg) < count_reg, "walk index outside occupied span")

    // a push on a full ring leaves the ring alone
    `DWS_ASSERT_NEXT(a_full_push, state_reg == S_EXEC && is_full && (func_reg == dws_pkg::FN_PUSH_FRONT || func_reg == dws_pkg::FN_PUSH_BACK), $stable(count_reg) && $stable(front_reg), "full push changed the ring")

    // every accepted command is decoded in the next cycle
    `DWS_ASSERT_NEXT(a_accept_exec, cmd_xfer, state_reg == S_EXEC, "accepted command not decoded")

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import dws_pkg::*;

    // undefined operation codes, the block drops them without a result
    localparam logic [FUNC_W-1:0] FN_SPARE_6 = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE_7 = 3'd7;

    localparam logic signed [DATA_W-1:0] VAL_MIN   = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX   = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] VAL_ONES  = 32'shffff_ffff;
    localparam logic signed [DATA_W-1:0] VAL_ABSENT = 32'sh0001_2345;

    localparam int RANDOM_ITEMS = 480;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int REPORT_MAX   = 10;

    // shadow copy of the ring, predicts the result transfers of each command
    class deque_shadow;
        logic signed [DATA_W-1:0] ring [DEPTH];
        logic [IDX_W-1:0]         front;
        logic [CNT_W-1:0]         count;
        res_t                     due_results [$];
        int                       errors;

        function new();
            front  = '0;
            count  = '0;
            errors = 0;
        endfunction

        function logic [IDX_W-1:0] slot(int off);
            return IDX_W'((int'(front) + off) % DEPTH);
        endfunction

        function void add_result(logic [STAT_W-1:0] st, int pos,
                                 logic signed [DATA_W-1:0] el, logic lst);
            res_t r;
            r.status   = st;
            r.position = POS_W'(pos);
            r.element  = el;
            r.last     = lst;
            due_results.push_back(r);
        endfunction

        // accepted command transfer: update the shadow, queue its results
        function void take_cmd(cmd_t c);
            int  i;
            bit  hit;
            hit = 0;
            case (c.func)
                FN_PUSH_FRONT, FN_PUSH_BACK:
                begin
                    if (int'(count) >= DEPTH)
                    begin
                        add_result(ST_FULL, 0, '0, 1'b1);
                    end
                    else
                    begin
                        if (c.func == FN_PUSH_FRONT)
                        begin
                            front = IDX_W'((int'(front) + DEPTH - 1) % DEPTH);
                            ring[front] = c.value;
                        end
                        else
                        begin
                            ring[slot(int'(count))] = c.value;
                        end
                        count = count + 1'b1;
                        add_result(ST_OK, 0, '0, 1'b1);
                    end
                end
                FN_POP_FRONT, FN_POP_BACK:
                begin
                    if (count == 0)
                    begin
                        add_result(ST_EMPTY, 0, '0, 1'b1);
                    end
                    else
                    begin
                        // pop back only shrinks the span
                        if (c.func == FN_POP_FRONT)
                        begin
                            front = slot(1);
                        end
                        count = count - 1'b1;
                        add_result(ST_OK, 0, '0, 1'b1);
                    end
                end
                FN_SEARCH:
                begin
                    if (count == 0)
                    begin
                        add_result(ST_EMPTY, 0, '0, 1'b1);
                    end
                    else
                    begin
                        for (i = 0; i < int'(count) && !hit; i++)
                        begin
                            if (ring[slot(i)] == c.value)
                            begin
                                add_result(ST_OK, i + 1, '0, 1'b1);
                                hit = 1;
                            end
                        end
                        if (!hit)
                        begin
                            add_result(ST_NOTFOUND, 0, '0, 1'b1);
                        end
                    end
                end
                FN_DUMP:
                begin
                    if (count == 0)
                    begin
                        add_result(ST_EMPTY, 0, '0, 1'b1);
                    end
                    else
                    begin
                        for (i = 0; i < int'(count); i++)
                        begin
                            add_result(ST_OK, 0, ring[slot(i)], i == int'(count) - 1);
                        end
                    end
                end
                default:
                begin
                    // spare codes: no state change, no result
                end
            endcase
        endfunction

        // accepted result transfer against the oldest prediction
        function void check_result(res_t got);
            res_t want;
            if (due_results.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                begin
                    $display("unexpected result: status %0d position %0d element %0d last %0d",
                             got.status, got.position, got.element, got.last);
                end
            end
            else
            begin
                want = due_results.pop_front();
                if (got.status !== want.status || got.position !== want.position ||
                    got.element !== want.element || got.last !== want.last)
                begin
                    errors++;
                    if (errors <= REPORT_MAX)
                    begin
                        $display("result mismatch: expected status %0d position %0d element %0d last %0d, got status %0d position %0d element %0d last %0d",
                                 want.status, want.position, want.element, want.last,
                                 got.status, got.position, got.element, got.last);
                    end
                end
            end
        endfunction

        function int pending();
            return due_results.size();
        endfunction
    endclass

    logic  clk;
    logic  rst_n;
    logic  cmd_valid;
    logic  cmd_stall;
    cmd_t  cmd;
    logic  res_valid;
    logic  res_stall;
    res_t  res;

    deque_shadow shadow;
    int          cycle_count;
    bit          idle_on;
    int          burst_left;

    deque_with_search dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // watchdog, also the time base for the stall pattern; starts at zero
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // receiver stall pattern: rotates through free-running, light, heavy
    // and periodic stretches so stalls land on every step of a dump walk
    always @(posedge clk)
    begin
        case ((cycle_count / 150) % 4)
            0: res_stall <= 1'b0;
            1: res_stall <= ($urandom_range(0, 3) == 0);
            2: res_stall <= ($urandom_range(0, 3) != 0);
            default: res_stall <= ((cycle_count % 8) < 3);
        endcase
    end

    // result transfers; values read in the active region are the pre-edge ones
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            shadow.check_result(res);
        end
    end

    // one command transfer; valid stays up until accepted, then the sender
    // either keeps going in its burst or drops valid for a random gap
    task automatic issue_cmd(input logic [FUNC_W-1:0] fn,
                             input logic signed [DATA_W-1:0] v);
        cmd_t c;
        c.func  = fn;
        c.value = v;
        cmd       <= c;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall)
        begin
            @(posedge clk);
        end
        shadow.take_cmd(c);
        if (idle_on)
        begin
            if (burst_left == 0)
            begin
                cmd_valid <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge clk);
                burst_left = $urandom_range(1, 12);
            end
            else
            begin
                burst_left--;
            end
        end
    endtask

    initial
    begin
        int                       i;
        int                       sent;
        int                       phase;
        int                       p_push;
        int                       p_pop;
        int                       r;
        logic [FUNC_W-1:0]        fn;
        logic signed [DATA_W-1:0] v;
        logic signed [DATA_W-1:0] pool [6];

        pool[0] = VAL_MIN;
        pool[1] = VAL_MAX;
        pool[2] = '0;
        pool[3] = VAL_ONES;
        pool[4] = 32'sd1;
        pool[5] = 32'sh5a5a_a5a5;

        shadow     = new();
        idle_on    = 1'b0;
        burst_left = 0;
        rst_n      <= 1'b0;
        cmd_valid  <= 1'b0;
        cmd        <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: back to back, no sender gaps
        // everything on an empty queue, then the spare codes
        issue_cmd(FN_DUMP, '0);
        issue_cmd(FN_POP_FRONT, '0);
        issue_cmd(FN_POP_BACK, '0);
        issue_cmd(FN_SEARCH, VAL_MAX);
        issue_cmd(FN_SPARE_6, VAL_ONES);
        issue_cmd(FN_SPARE_7, VAL_MIN);
        // extremes at both ends, fill up to full, then one push on the full queue
        issue_cmd(FN_PUSH_FRONT, VAL_MIN);
        issue_cmd(FN_PUSH_BACK, VAL_MAX);
        for (i = 0; i < DEPTH - 3; i++)
        begin
            issue_cmd((i % 2) ? FN_PUSH_FRONT : FN_PUSH_BACK, $urandom);
        end
        issue_cmd(FN_PUSH_BACK, VAL_ONES);
        issue_cmd(FN_PUSH_FRONT, VAL_MAX);
        // match on the very last entry, then a miss, then a full dump
        issue_cmd(FN_SEARCH, VAL_ONES);
        issue_cmd(FN_SEARCH, VAL_ABSENT);
        issue_cmd(FN_DUMP, '0);
        // pop back must drop the back entry, not its neighbor
        issue_cmd(FN_POP_BACK, '0);
        issue_cmd(FN_SEARCH, VAL_ONES);
        issue_cmd(FN_POP_FRONT, '0);

        // random: phases lean toward filling, draining or mixing so the
        // queue keeps crossing full and empty
        idle_on = 1'b1;
        sent    = 0;
        phase   = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent % 40 == 0)
            begin
                phase = $urandom_range(0, 2);
            end
            p_push = (phase == 0) ? 60 : (phase == 1) ? 15 : 35;
            p_pop  = (phase == 0) ? 15 : (phase == 1) ? 60 : 35;

            case ($urandom_range(0, 3))
                0: v = pool[$urandom_range(0, 5)];
                default: v = $urandom;
            endcase

            r = $urandom_range(0, 99);
            if (r < 3)
            begin
                fn = $urandom_range(0, 1) ? FN_SPARE_6 : FN_SPARE_7;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < p_push)
                begin
                    fn = $urandom_range(0, 1) ? FN_PUSH_FRONT : FN_PUSH_BACK;
                end
                else if (r < p_push + p_pop)
                begin
                    fn = $urandom_range(0, 1) ? FN_POP_FRONT : FN_POP_BACK;
                end
                else if (r < 92)
                begin
                    fn = FN_SEARCH;
                    // mostly keys that are held, at any position
                    if (shadow.count != 0 && $urandom_range(0, 2) != 0)
                    begin
                        v = shadow.ring[shadow.slot($urandom_range(0, int'(shadow.count) - 1))];
                    end
                end
                else
                begin
                    fn = FN_DUMP;
                end
                sent++;
            end
            issue_cmd(fn, v);
        end
        cmd_valid <= 1'b0;

        // drain, then a short quiet spell to catch stray results
        while (shadow.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);

        if (shadow.errors == 0 && shadow.pending() == 0)
        begin
            $display("tb_top OK");
        end
        else
        begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
